>>> hw/rtl/des_fr_pkg.sv
package des_fr_pkg;

    // Request and result payloads
    typedef struct packed {
        logic [31:0] left_in;
        logic [31:0] right_in;
        logic [47:0] round_key;
    } t_des_fr_req;

    typedef struct packed {
        logic [31:0] left_out;
        logic [31:0] right_out;
    } t_des_fr_res;

    // Stage 1 -> 2: halves plus expanded right XOR key
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [47:0] mix;
    } t_des_fr_s1;

    // Stage 2 -> 3: halves plus S-box output
    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] sout;
    } t_des_fr_s2;

    localparam int NUM_SBOX = 8;

    // S-box rows, column 0 in the most significant nibble
    localparam logic [0:15][3:0] SBOX [0:NUM_SBOX-1][0:3] = '{
        '{64'hE4D12FB83A6C5907, 64'h0F74E2D1A6CB9538,
          64'h41E8D62BFC973A50, 64'hFC8249175B3EA06D},
        '{64'hF18E6B34972DC05A, 64'h3D47F28EC01A69B5,
          64'h0E7BA4D158C6932F, 64'hD8A13F42B67C05E9},
        '{64'hA09E63F51DC7B428, 64'hD709346A285ECBF1,
          64'hD6498F30B12C5AE7, 64'h1AD069874FE3B52C},
        '{64'h7DE3069A1285BC4F, 64'hD8B56F03472C1AE9,
          64'hA690CB7DF13E5284, 64'h3F06A1D8945BC72E},
        '{64'h2C417AB6853FD0E9, 64'hEB2C47D150FA3986,
          64'h421BAD78F9C5630E, 64'hB8C71E2D6F09A453},
        '{64'hC1AF92680D34E75B, 64'hAF427C9561DE0B38,
          64'h9EF528C3704A1DB6, 64'h432C95FABE17608D},
        '{64'h4B2EF08D3C975A61, 64'hD0B7491AE35C2F86,
          64'h14BDC37EAF680592, 64'h6BD814A7950FE23C},
        '{64'hD2846FB1A93E50C7, 64'h1FD8A374C56B0E92,
          64'h7B419CE206ADF358, 64'h21E74A8DFC90356B}
    };

    // P wiring, standard numbering (1 = MSB), output bit 1 first
    localparam logic [0:31][5:0] P_TAB = {
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    // E expansion: group g takes bits 4g-1 .. 4g+4 of the right half (wrapping)
    function automatic logic [47:0] expand_e(input logic [31:0] r);
        logic [47:0] e;
        logic [4:0]  pos;
        e   = '0;
        pos = '0;
        for (int g = 0; g < NUM_SBOX; g++) begin
            for (int k = 0; k < 6; k++) begin
                pos = 5'(31 - ((4 * g + k + 31) & 31));
                e[47 - (6 * g + k)] = r[pos];
            end
        end
        return e;
    endfunction

    // Eight 6-to-4 lookups: row from the outer bits, column from the middle four
    function automatic logic [31:0] subst(input logic [47:0] x);
        logic [31:0] s;
        logic [5:0]  six;
        s   = '0;
        six = '0;
        for (int g = 0; g < NUM_SBOX; g++) begin
            six = x[47 - 6 * g -: 6];
            s[31 - 4 * g -: 4] = SBOX[g][{six[5], six[0]}][six[4:1]];
        end
        return s;
    endfunction

    // P permutation
    function automatic logic [31:0] permute_p(input logic [31:0] x);
        logic [31:0] y;
        logic [5:0]  pos;
        y   = '0;
        pos = '0;
        for (int i = 0; i < 32; i++) begin
            pos = 6'd32 - P_TAB[i];
            y[31 - i] = x[pos[4:0]];
        end
        return y;
    endfunction

endpackage

>>> hw/rtl/des_fr_expand.sv
module des_fr_expand (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  des_fr_pkg::t_des_fr_req i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output des_fr_pkg::t_des_fr_s1 o_data
);
    import des_fr_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_des_fr_s1 r_data;
    t_des_fr_s1 n_data;
    logic       load;

    // Stage advances when empty or when downstream takes its request
    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = o_ready ? i_valid : r_valid;
        n_data.left  = i_data.left_in;
        n_data.right = i_data.right_in;
        n_data.mix   = expand_e(i_data.right_in) ^ i_data.round_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/des_fr_sbox.sv
module des_fr_sbox (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  des_fr_pkg::t_des_fr_s1 i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output des_fr_pkg::t_des_fr_s2 o_data
);
    import des_fr_pkg::*;

    logic       r_valid;
    logic       n_valid;
    t_des_fr_s2 r_data;
    t_des_fr_s2 n_data;
    logic       load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // Substitution through the eight S-boxes
    always_comb begin
        n_valid = o_ready ? i_valid : r_valid;
        n_data.left  = i_data.left;
        n_data.right = i_data.right;
        n_data.sout  = subst(i_data.mix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/des_fr_perm.sv
module des_fr_perm (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  des_fr_pkg::t_des_fr_s2 i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output des_fr_pkg::t_des_fr_res o_data
);
    import des_fr_pkg::*;

    logic        r_valid;
    logic        n_valid;
    t_des_fr_res r_data;
    t_des_fr_res n_data;
    logic        load;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    // P permutation and the Feistel swap
    always_comb begin
        n_valid = o_ready ? i_valid : r_valid;
        n_data.left_out  = i_data.right;
        n_data.right_out = i_data.left ^ permute_p(i_data.sout);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/des_feistel_round_core.sv
// One DES Feistel round (FIPS 46 E, S-box and P tables). Each request carries
// the left and right halves and a 48-bit round key; each result gives
// left_out = right_in and right_out = left_in XOR f(right_in, round_key).
// Three register stages (E expansion and key XOR, S-box lookup, P permutation
// and XOR into the left half) lie between acceptance and o_res_valid; a new
// request can be accepted every cycle unless stalled. Each stage holds its
// request while the next one is full, so backpressure on the result side
// stalls the pipe without dropping or repeating anything; up to three
// requests can be in flight. There is no state beyond the pipe itself.
module des_feistel_round_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    output logic                    o_req_ready,
    input  des_fr_pkg::t_des_fr_req i_req,
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output des_fr_pkg::t_des_fr_res o_res
);
    import des_fr_pkg::*;

    logic       s1_valid;
    logic       s1_ready;
    t_des_fr_s1 s1_data;
    logic       s2_valid;
    logic       s2_ready;
    t_des_fr_s2 s2_data;

    // Stage 1: expansion and key mix
    des_fr_expand u_expand (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_data  (i_req),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_data  (s1_data)
    );

    // Stage 2: S-boxes
    des_fr_sbox u_sbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_data  (s1_data),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_data  (s2_data)
    );

    // Stage 3: permutation, swap, output register
    des_fr_perm u_perm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_data  (s2_data),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (o_res)
    );

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;

    import des_fr_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int RAND_PER_PHASE = 217;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // E expansion selection, standard numbering (1 = MSB), output bit 1 first
    localparam int E_SEL [48] = '{
        32,  1,  2,  3,  4,  5,  4,  5,  6,  7,  8,  9,
         8,  9, 10, 11, 12, 13, 12, 13, 14, 15, 16, 17,
        16, 17, 18, 19, 20, 21, 20, 21, 22, 23, 24, 25,
        24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32,  1
    };

    // P permutation, same numbering
    localparam int P_SEL [32] = '{
        16,  7, 20, 21, 29, 12, 28, 17,  1, 15, 23, 26,  5, 18, 31, 10,
         2,  8, 24, 14, 32, 27,  3,  9, 19, 13, 30,  6, 22, 11,  4, 25
    };

    // S-boxes: [box][row][column]
    localparam int SBOX_LUT [8][4][16] = '{
        '{'{14, 4,13, 1, 2,15,11, 8, 3,10, 6,12, 5, 9, 0, 7},
          '{ 0,15, 7, 4,14, 2,13, 1,10, 6,12,11, 9, 5, 3, 8},
          '{ 4, 1,14, 8,13, 6, 2,11,15,12, 9, 7, 3,10, 5, 0},
          '{15,12, 8, 2, 4, 9, 1, 7, 5,11, 3,14,10, 0, 6,13}},
        '{'{15, 1, 8,14, 6,11, 3, 4, 9, 7, 2,13,12, 0, 5,10},
          '{ 3,13, 4, 7,15, 2, 8,14,12, 0, 1,10, 6, 9,11, 5},
          '{ 0,14, 7,11,10, 4,13, 1, 5, 8,12, 6, 9, 3, 2,15},
          '{13, 8,10, 1, 3,15, 4, 2,11, 6, 7,12, 0, 5,14, 9}},
        '{'{10, 0, 9,14, 6, 3,15, 5, 1,13,12, 7,11, 4, 2, 8},
          '{13, 7, 0, 9, 3, 4, 6,10, 2, 8, 5,14,12,11,15, 1},
          '{13, 6, 4, 9, 8,15, 3, 0,11, 1, 2,12, 5,10,14, 7},
          '{ 1,10,13, 0, 6, 9, 8, 7, 4,15,14, 3,11, 5, 2,12}},
        '{'{ 7,13,14, 3, 0, 6, 9,10, 1, 2, 8, 5,11,12, 4,15},
          '{13, 8,11, 5, 6,15, 0, 3, 4, 7, 2,12, 1,10,14, 9},
          '{10, 6, 9, 0,12,11, 7,13,15, 1, 3,14, 5, 2, 8, 4},
          '{ 3,15, 0, 6,10, 1,13, 8, 9, 4, 5,11,12, 7, 2,14}},
        '{'{ 2,12, 4, 1, 7,10,11, 6, 8, 5, 3,15,13, 0,14, 9},
          '{14,11, 2,12, 4, 7,13, 1, 5, 0,15,10, 3, 9, 8, 6},
          '{ 4, 2, 1,11,10,13, 7, 8,15, 9,12, 5, 6, 3, 0,14},
          '{11, 8,12, 7, 1,14, 2,13, 6,15, 0, 9,10, 4, 5, 3}},
        '{'{12, 1,10,15, 9, 2, 6, 8, 0,13, 3, 4,14, 7, 5,11},
          '{10,15, 4, 2, 7,12, 9, 5, 6, 1,13,14, 0,11, 3, 8},
          '{ 9,14,15, 5, 2, 8,12, 3, 7, 0, 4,10, 1,13,11, 6},
          '{ 4, 3, 2,12, 9, 5,15,10,11,14, 1, 7, 6, 0, 8,13}},
        '{'{ 4,11, 2,14,15, 0, 8,13, 3,12, 9, 7, 5,10, 6, 1},
          '{13, 0,11, 7, 4, 9, 1,10,14, 3, 5,12, 2,15, 8, 6},
          '{ 1, 4,11,13,12, 3, 7,14,10,15, 6, 8, 0, 5, 9, 2},
          '{ 6,11,13, 8, 1, 4,10, 7, 9, 5, 0,15,14, 2, 3,12}},
        '{'{13, 2, 8, 4, 6,15,11, 1,10, 9, 3,14, 5, 0,12, 7},
          '{ 1,15,13, 8,10, 3, 7, 4,12, 5, 6,11, 0,14, 9, 2},
          '{ 7,11, 4, 1, 9,12,14, 2, 0, 6,10,13,15, 3, 5, 8},
          '{ 2, 1,14, 7, 4,10, 8,13,15,12, 9, 0, 3, 5, 6,11}}
    };

    // Directed stimulus row; known rows carry a hand-checked result
    typedef struct packed {
        t_des_fr_req req;
        logic        known;
        t_des_fr_res res;
    } t_round_vec;

    localparam int NUM_DIR = 14;

    localparam t_round_vec DIR_TAB [NUM_DIR] = '{
        '{'{32'h00000000, 32'h00000000, 48'h000000000000}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'hFFFFFFFF, 32'h00000000, 48'h000000000000}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'h00000000, 32'hFFFFFFFF, 48'h000000000000}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'h00000000, 32'h00000000, 48'hFFFFFFFFFFFF}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'h55555555, 32'hAAAAAAAA, 48'h555555555555}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'hAAAAAAAA, 32'h55555555, 48'hAAAAAAAAAAAA}, 1'b0, '{32'h0, 32'h0}},
        // first two rounds of the classic worked example
        '{'{32'hCC00CCFF, 32'hF0AAF0AA, 48'h1B02EFFC7072}, 1'b1,
          '{32'hF0AAF0AA, 32'hEF4A6544}},
        '{'{32'hF0AAF0AA, 32'hEF4A6544, 48'h79AED9DBC9E5}, 1'b1,
          '{32'hEF4A6544, 32'hCC017709}},
        // E wrap-around bits only
        '{'{32'h00000000, 32'h80000001, 48'h000000000000}, 1'b0, '{32'h0, 32'h0}},
        // every box on row 1, row 2, row 3, then row 0 last column
        '{'{32'h12345678, 32'h00000000, 48'h041041041041}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'h9ABCDEF0, 32'h00000000, 48'h820820820820}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'h0F0F0F0F, 32'h00000000, 48'h861861861861}, 1'b0, '{32'h0, 32'h0}},
        '{'{32'hF0F0F0F0, 32'h00000000, 48'h79E79E79E79E}, 1'b0, '{32'h0, 32'h0}}
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    t_des_fr_req req       = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    t_des_fr_res res;

    t_des_fr_res round_q [$];
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_cnt        = 0;
    int unsigned quiet_cycles   = 0;

    des_feistel_round_core uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One DES round: E expansion, key mix, S-boxes, P, XOR into left half
    function automatic t_des_fr_res feistel_round(input t_des_fr_req r);
        logic [47:0] mixed;
        logic [31:0] sbox_out;
        logic [5:0]  chunk;
        t_des_fr_res o;
        for (int i = 0; i < 48; i++) begin
            mixed[47 - i] = r.right_in[32 - E_SEL[i]];
        end
        mixed = mixed ^ r.round_key;
        for (int g = 0; g < 8; g++) begin
            chunk = mixed[47 - 6 * g -: 6];
            sbox_out[31 - 4 * g -: 4] = 4'(SBOX_LUT[g][{chunk[5], chunk[0]}][chunk[4:1]]);
        end
        for (int i = 0; i < 32; i++) begin
            o.right_out[31 - i] = r.left_in[31 - i] ^ sbox_out[32 - P_SEL[i]];
        end
        o.left_out = r.right_in;
        return o;
    endfunction

    // Mostly uniform requests, some with fields pinned to their extremes
    function automatic t_des_fr_req rand_req();
        t_des_fr_req r;
        r.left_in   = $urandom;
        r.right_in  = $urandom;
        r.round_key = {16'($urandom), 32'($urandom)};
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(2))
                0: r.left_in   = $urandom_range(1) ? '1 : '0;
                1: r.right_in  = $urandom_range(1) ? '1 : '0;
                default: r.round_key = $urandom_range(1) ? '1 : '0;
            endcase
        end
        return r;
    endfunction

    // Present one request, hold it until taken, then queue its result
    task automatic push_req(input t_des_fr_req r, input t_des_fr_res want);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        round_q.push_back(want);
    endtask

    // Result check, receiver stalls and watchdog
    always @(posedge clk) begin : res_mon
        t_des_fr_res want;
        if (rst_n && res_valid && res_ready) begin
            if (round_q.size() == 0) begin
                $error("unexpected result: left_out=%h right_out=%h",
                       res.left_out, res.right_out);
                err_cnt++;
            end else begin
                want = round_q.pop_front();
                if (res.left_out !== want.left_out) begin
                    $error("left_out: expected %h, got %h", want.left_out, res.left_out);
                    err_cnt++;
                end
                if (res.right_out !== want.right_out) begin
                    $error("right_out: expected %h, got %h", want.right_out, res.right_out);
                    err_cnt++;
                end
            end
        end
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
        if ((req_valid && req_ready) || (res_valid && res_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("des_feistel_round_core regression: fail");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_des_fr_req r;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 28;
        recv_stall_pct = 55;
        for (int i = 0; i < NUM_DIR; i++) begin
            push_req(DIR_TAB[i].req,
                     DIR_TAB[i].known ? DIR_TAB[i].res : feistel_round(DIR_TAB[i].req));
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 55;
                end
                1: begin
                    send_idle_pct  = 55;
                    recv_stall_pct = 28;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                r = rand_req();
                push_req(r, feistel_round(r));
            end
            // after the first phase, let the pipe drain completely before the next one
            if (ph == 0) begin
                req_valid <= 1'b0;
                while (round_q.size() != 0) @(posedge clk);
            end
        end

        req_valid <= 1'b0;
        while (round_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (round_q.size() != 0) begin
            $error("%0d results never arrived", round_q.size());
            err_cnt++;
        end

        if (err_cnt == 0) begin
            $display("des_feistel_round_core regression: pass");
        end else begin
            $display("des_feistel_round_core regression: fail");
        end
        $finish;
    end

endmodule
